FILE: src/euler_angle_rotation_3d_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Euler angle rotation block
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef EULER_ANGLE_ROTATION_3D_MACROS_SVH
`define EULER_ANGLE_ROTATION_3D_MACROS_SVH

// same-cycle implication
`define EART_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EART_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/eart_pkg.sv
// ---------------------------------------------------------------------------
// eart_pkg
// Types, constants and arithmetic helpers for the Euler angle rotation block.
// ---------------------------------------------------------------------------
package eart_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COORD_BITS     = 16;
  localparam int COEF_FRAC_BITS = 15;  // must stay below 30

  localparam int COEF_W  = COEF_FRAC_BITS + 2;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int OUT_W   = COORD_BITS + 1;
  localparam int ACC_W   = COEF_W + COORD_BITS + 2;
  localparam int PHASE_W = 32;
  localparam int Q_W     = 31;  // Q30 value in [0, 1]

  localparam int NUM_REGS   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ANGLE_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = CFG_IDX_W'(2);

  localparam int NUM_COEF = 9;
  localparam int M_XX = 0;
  localparam int M_XY = 1;
  localparam int M_XZ = 2;
  localparam int M_YX = 3;
  localparam int M_YY = 4;
  localparam int M_YZ = 5;
  localparam int M_ZX = 6;
  localparam int M_ZY = 7;
  localparam int M_ZZ = 8;

  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [COEF_W:0]       coef_sum_t;
  typedef coef_t                        coef_mat_t [NUM_COEF];
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]      out_t;
  typedef logic [ANGLE_BITS-1:0]        angle_t;
  typedef logic [Q_W-1:0]               q30_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    CG_IDLE,
    CG_SINE,
    CG_PROD,
    CG_SUM
  } cg_state_t;

  localparam coef_t COEF_ONE = coef_t'(64'sd1 <<< COEF_FRAC_BITS);
  localparam q30_t  Q30_ONE  = q30_t'(64'd1 << 30);
  localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(64'd1 << 30);

  localparam int   RND_SH   = 30 - COEF_FRAC_BITS;
  localparam logic [Q_W:0] RND_HALF = (Q_W+1)'(64'd1 << (RND_SH - 1));

  // odd Taylor terms of sin(pi/2*u), Q30
  localparam q30_t SINE_POLY [7] = '{
    31'd1686629713, 31'd693598668, 31'd85569305, 31'd5026995,
    31'd172272,     31'd3864,      31'd61
  };

  localparam logic signed [PROD_W-1:0] QMUL_HALF =
    PROD_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0]  ACC_HALF  =
    ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0]  OUT_MAX   =
    ACC_W'((64'sd1 <<< COORD_BITS) - 64'sd1);
  localparam logic signed [ACC_W-1:0]  OUT_MIN   =
    ACC_W'(-(64'sd1 <<< COORD_BITS));

  // Q1.F product, round half up
  function automatic coef_t qmul(input coef_t a, input coef_t b);
    logic signed [PROD_W-1:0] p;
    p = a * b + QMUL_HALF;
    return coef_t'(p[COEF_FRAC_BITS +: COEF_W]);
  endfunction

  function automatic coef_t coef_sat(input coef_sum_t v);
    coef_sum_t lim;
    lim = coef_sum_t'(COEF_ONE);
    if (v > lim) begin
      return COEF_ONE;
    end else if (v < -lim) begin
      return -COEF_ONE;
    end
    return coef_t'(v[COEF_W-1:0]);
  endfunction

  // one row of the matrix times the point, rounded and saturated
  function automatic out_t rot_row(input coef_t a, input coef_t b, input coef_t c,
                                   input coord_t x, input coord_t y, input coord_t z);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] sh;
    acc = a * x + b * y + c * z + ACC_HALF;
    sh  = acc >>> COEF_FRAC_BITS;
    if (sh > OUT_MAX) begin
      sh = OUT_MAX;
    end else if (sh < OUT_MIN) begin
      sh = OUT_MIN;
    end
    return out_t'(sh[OUT_W-1:0]);
  endfunction

endpackage

FILE: src/eart_coef_gen.sv
// ---------------------------------------------------------------------------
// eart_coef_gen
// Angle registers and rotation matrix generator. A shared 31x31 multiplier
// evaluates the six sines and cosines one Horner step a cycle, then two
// registered stages form the nine Q1.F coefficients.
// ---------------------------------------------------------------------------
module eart_coef_gen (
  input  logic                clk,
  input  logic                rst_n,
  input  eart_pkg::cfg_wr_t   cfg,
  output logic                busy,
  output eart_pkg::coef_mat_t coef
);

  localparam logic [2:0] SI_SX   = 3'd0;
  localparam logic [2:0] SI_CX   = 3'd1;
  localparam logic [2:0] SI_SY   = 3'd2;
  localparam logic [2:0] SI_CY   = 3'd3;
  localparam logic [2:0] SI_SZ   = 3'd4;
  localparam logic [2:0] SI_CZ   = 3'd5;
  localparam logic [2:0] SI_LAST = SI_CZ;

  localparam logic [3:0] STEP_PHASE = 4'd0;
  localparam logic [3:0] STEP_SQR   = 4'd1;
  localparam logic [3:0] STEP_LAST  = 4'd8;
  localparam logic [3:0] HORN_BASE  = 4'd7;  // step 2 uses term 5

  eart_pkg::cg_state_t state_r, state_nxt;
  logic [2:0]          sidx_r, sidx_nxt;
  logic [3:0]          step_r, step_nxt;

  eart_pkg::angle_t angle_r [eart_pkg::NUM_REGS];

  eart_pkg::q30_t u_r, x2_r, t_r;
  logic           neg_r;
  eart_pkg::coef_t sin_r [6];

  eart_pkg::coef_t czsy_r, szsy_r;
  eart_pkg::coef_t czcy_r, szcx_r, szsx_r, szcy_r, czcx_r, czsx_r, cysx_r, cycx_r;

  eart_pkg::angle_t                  ang;
  logic [eart_pkg::PHASE_W-1:0]      phase;
  eart_pkg::q30_t                    u_nxt;
  eart_pkg::q30_t                    mul_a, mul_b;
  logic [2*eart_pkg::Q_W-1:0]        mul_p;
  logic [eart_pkg::Q_W:0]            mul_hi;
  logic [eart_pkg::Q_W:0]            horner;
  logic [2:0]                        hk;
  logic [eart_pkg::Q_W:0]            rnd;
  logic [eart_pkg::COEF_W-1:0]       mag;
  eart_pkg::coef_t                   sine_val;

  // ---- angle registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < eart_pkg::NUM_REGS; i++) begin
        angle_r[i] <= '0;
      end
    end else if (cfg.we) begin
      unique case (cfg.idx)
        eart_pkg::REG_ANGLE_X: angle_r[0] <= cfg.data[eart_pkg::ANGLE_BITS-1:0];
        eart_pkg::REG_ANGLE_Y: angle_r[1] <= cfg.data[eart_pkg::ANGLE_BITS-1:0];
        eart_pkg::REG_ANGLE_Z: angle_r[2] <= cfg.data[eart_pkg::ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eart_pkg::CG_IDLE;
      sidx_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sidx_r  <= sidx_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sidx_nxt  = sidx_r;
    step_nxt  = step_r;
    if (cfg.we) begin
      // any write restarts the whole pass
      state_nxt = eart_pkg::CG_SINE;
      sidx_nxt  = '0;
      step_nxt  = '0;
    end else begin
      unique case (state_r)
        eart_pkg::CG_IDLE: state_nxt = eart_pkg::CG_IDLE;
        eart_pkg::CG_SINE: begin
          if (step_r == STEP_LAST) begin
            step_nxt = '0;
            if (sidx_r == SI_LAST) begin
              state_nxt = eart_pkg::CG_PROD;
            end else begin
              sidx_nxt = sidx_r + 3'd1;
            end
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
        eart_pkg::CG_PROD: state_nxt = eart_pkg::CG_SUM;
        eart_pkg::CG_SUM:  state_nxt = eart_pkg::CG_IDLE;
      endcase
    end
  end

  assign busy = (state_r != eart_pkg::CG_IDLE);

  // ---- sine unit
  always_comb begin
    ang   = angle_r[sidx_r[2:1]];
    phase = {ang, {(eart_pkg::PHASE_W - eart_pkg::ANGLE_BITS){1'b0}}}
          + (sidx_r[0] ? eart_pkg::QUARTER_TURN : '0);
    if (phase[30]) begin
      u_nxt = eart_pkg::Q30_ONE - {1'b0, phase[29:0]};
    end else begin
      u_nxt = {1'b0, phase[29:0]};
    end

    if (step_r == STEP_SQR) begin
      mul_a = u_r;
      mul_b = u_r;
    end else if (step_r == STEP_LAST) begin
      mul_a = t_r;
      mul_b = u_r;
    end else begin
      mul_a = t_r;
      mul_b = x2_r;
    end
    mul_p  = mul_a * mul_b;
    mul_hi = mul_p[2*eart_pkg::Q_W-1:30];

    hk     = 3'(HORN_BASE - step_r);
    horner = {1'b0, eart_pkg::SINE_POLY[hk]} - mul_hi;

    rnd = (mul_hi + eart_pkg::RND_HALF) >> eart_pkg::RND_SH;
    if (rnd > (eart_pkg::Q_W+1)'(eart_pkg::COEF_ONE)) begin
      mag = eart_pkg::COEF_ONE;
    end else begin
      mag = rnd[eart_pkg::COEF_W-1:0];
    end
    sine_val = neg_r ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (state_r == eart_pkg::CG_SINE) begin
      if (step_r == STEP_PHASE) begin
        u_r   <= u_nxt;
        neg_r <= phase[31];
      end else if (step_r == STEP_SQR) begin
        x2_r <= mul_hi[eart_pkg::Q_W-1:0];
        t_r  <= eart_pkg::SINE_POLY[6];
      end else if (step_r == STEP_LAST) begin
        sin_r[sidx_r] <= sine_val;
      end else begin
        t_r <= horner[eart_pkg::Q_W-1:0];
      end
    end
  end

  // ---- coefficient stages
  always_ff @(posedge clk) begin
    if (state_r == eart_pkg::CG_PROD) begin
      czsy_r <= eart_pkg::qmul(sin_r[SI_CZ], sin_r[SI_SY]);
      szsy_r <= eart_pkg::qmul(sin_r[SI_SZ], sin_r[SI_SY]);
      czcy_r <= eart_pkg::qmul(sin_r[SI_CZ], sin_r[SI_CY]);
      szcx_r <= eart_pkg::qmul(sin_r[SI_SZ], sin_r[SI_CX]);
      szsx_r <= eart_pkg::qmul(sin_r[SI_SZ], sin_r[SI_SX]);
      szcy_r <= eart_pkg::qmul(sin_r[SI_SZ], sin_r[SI_CY]);
      czcx_r <= eart_pkg::qmul(sin_r[SI_CZ], sin_r[SI_CX]);
      czsx_r <= eart_pkg::qmul(sin_r[SI_CZ], sin_r[SI_SX]);
      cysx_r <= eart_pkg::qmul(sin_r[SI_CY], sin_r[SI_SX]);
      cycx_r <= eart_pkg::qmul(sin_r[SI_CY], sin_r[SI_CX]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < eart_pkg::NUM_COEF; i++) begin
        coef[i] <= ((i == eart_pkg::M_XX) || (i == eart_pkg::M_YY) || (i == eart_pkg::M_ZZ))
                   ? eart_pkg::COEF_ONE : '0;
      end
    end else if (state_r == eart_pkg::CG_SUM) begin
      coef[eart_pkg::M_XX] <= eart_pkg::coef_sat(eart_pkg::coef_sum_t'(czcy_r));
      coef[eart_pkg::M_XY] <= eart_pkg::coef_sat(
        eart_pkg::coef_sum_t'(eart_pkg::qmul(czsy_r, sin_r[SI_SX]))
        - eart_pkg::coef_sum_t'(szcx_r));
      coef[eart_pkg::M_XZ] <= eart_pkg::coef_sat(
        eart_pkg::coef_sum_t'(eart_pkg::qmul(czsy_r, sin_r[SI_CX]))
        + eart_pkg::coef_sum_t'(szsx_r));
      coef[eart_pkg::M_YX] <= eart_pkg::coef_sat(eart_pkg::coef_sum_t'(szcy_r));
      coef[eart_pkg::M_YY] <= eart_pkg::coef_sat(
        eart_pkg::coef_sum_t'(eart_pkg::qmul(szsy_r, sin_r[SI_SX]))
        + eart_pkg::coef_sum_t'(czcx_r));
      coef[eart_pkg::M_YZ] <= eart_pkg::coef_sat(
        eart_pkg::coef_sum_t'(eart_pkg::qmul(szsy_r, sin_r[SI_CX]))
        - eart_pkg::coef_sum_t'(czsx_r));
      coef[eart_pkg::M_ZX] <= eart_pkg::coef_sat(-eart_pkg::coef_sum_t'(sin_r[SI_SY]));
      coef[eart_pkg::M_ZY] <= eart_pkg::coef_sat(eart_pkg::coef_sum_t'(cysx_r));
      coef[eart_pkg::M_ZZ] <= eart_pkg::coef_sat(eart_pkg::coef_sum_t'(cycx_r));
    end
  end

endmodule

FILE: src/euler_angle_rotation_3d.sv
// ---------------------------------------------------------------------------
// euler_angle_rotation_3d
// Rotates streamed 3D points by the matrix built from three Euler angles
// (about x, then y, then z).
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    in_x_in, in_y_in, in_z_in
//   out      source     out_valid/out_stall  out_x_out, out_y_out, out_z_out
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// One point per cycle while neither in_stall nor out_stall holds it; each point
// passes the input register, then the result register. A cfg write rebuilds the
// matrix (six sines at nine steps on the shared multiplier, two product stages); in_stall is high meanwhile.
// Reset loads zero angles and the identity matrix.
// out_stall holds the result register and backs up into the input register.
// ---------------------------------------------------------------------------
`include "euler_angle_rotation_3d_macros.svh"

module euler_angle_rotation_3d (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [eart_pkg::COORD_BITS-1:0] in_x_in,
  input  logic signed [eart_pkg::COORD_BITS-1:0] in_y_in,
  input  logic signed [eart_pkg::COORD_BITS-1:0] in_z_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [eart_pkg::OUT_W-1:0]   out_x_out,
  output logic signed [eart_pkg::OUT_W-1:0]   out_y_out,
  output logic signed [eart_pkg::OUT_W-1:0]   out_z_out,
  input  logic                                cfg_we,
  input  logic [eart_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eart_pkg::CFG_DATA_W-1:0]     cfg_data
);

  eart_pkg::cfg_wr_t   cfg_wr;
  eart_pkg::coef_mat_t coef;
  logic                cg_busy;

  logic            v1_r, v1_nxt;
  logic            v2_r, v2_nxt;
  logic            adv2;
  logic            in_acc;
  eart_pkg::coord_t x1_r, y1_r, z1_r;
  eart_pkg::out_t   xo_r, yo_r, zo_r;
  eart_pkg::out_t   xo_nxt, yo_nxt, zo_nxt;

  assign cfg_wr.we   = cfg_we;
  assign cfg_wr.idx  = cfg_index;
  assign cfg_wr.data = cfg_data;

  eart_coef_gen u_coef_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .busy  (cg_busy),
    .coef  (coef)
  );

  // ---- handshake
  always_comb begin
    adv2     = !v2_r || !out_stall;
    in_stall = cg_busy || cfg_we || (v1_r && !adv2);
    in_acc   = in_valid && !in_stall;
    v1_nxt   = in_acc || (v1_r && !adv2);
    v2_nxt   = adv2 ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // ---- datapath
  always_comb begin
    xo_nxt = eart_pkg::rot_row(coef[eart_pkg::M_XX], coef[eart_pkg::M_XY],
                               coef[eart_pkg::M_XZ], x1_r, y1_r, z1_r);
    yo_nxt = eart_pkg::rot_row(coef[eart_pkg::M_YX], coef[eart_pkg::M_YY],
                               coef[eart_pkg::M_YZ], x1_r, y1_r, z1_r);
    zo_nxt = eart_pkg::rot_row(coef[eart_pkg::M_ZX], coef[eart_pkg::M_ZY],
                               coef[eart_pkg::M_ZZ], x1_r, y1_r, z1_r);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x1_r <= in_x_in;
      y1_r <= in_y_in;
      z1_r <= in_z_in;
    end
    if (adv2 && v1_r) begin
      xo_r <= xo_nxt;
      yo_r <= yo_nxt;
      zo_r <= zo_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_x_out = xo_r;
  assign out_y_out = yo_r;
  assign out_z_out = zo_r;

  // ---- assertions
  `EART_ASSERT_NXT(a_cfg_starts_rebuild, cfg_we, cg_busy, "cfg write did not start rebuild")
  `EART_ASSERT_IMP(a_no_accept_in_rebuild, cg_busy, in_stall, "item accepted during rebuild")
  `EART_ASSERT_NXT(a_blocked_item_kept, v1_r && !adv2, v1_r && v2_r, "blocked item lost")

endmodule

FILE: tb/euler_angle_rotation_3d_test.sv
// ---------------------------------------------------------------------------
// euler_angle_rotation_3d_test
// Self-checking bench for the Euler angle rotation block. Points are streamed
// under random valid/stall gaps. Each accepted item is rotated by a local
// fixed-point copy of the sine table and coefficient matrix, and each result
// is checked field by field in order. Angle sets, extremes included, are
// changed only while the pipeline is empty.
// ---------------------------------------------------------------------------
module euler_angle_rotation_3d_test;
  timeunit 1ns;
  timeprecision 1ps;
  import eart_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 12;
  localparam int PHASE_POINTS   = 135;
  localparam int MAX_PRINTS     = 30;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = ~COORD_MIN;

  localparam angle_t QUARTER = angle_t'(1 << (ANGLE_BITS - 2));
  localparam angle_t HALF    = angle_t'(1 << (ANGLE_BITS - 1));
  localparam angle_t ANG_MAX = '1;

  // odd Taylor terms of sin(pi/2*u), Q30
  localparam longint unsigned HALF_PI_TAYLOR [7] = '{
    64'd1686629713, 64'd693598668, 64'd85569305, 64'd5026995,
    64'd172272,     64'd3864,      64'd61
  };
  localparam longint unsigned Q30_UNIT  = 64'd1 << 30;
  localparam longint          COEF_UNIT = 64'sd1 <<< COEF_FRAC_BITS;
  localparam longint          HALF_LSB  = 64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam longint          POS_LIMIT = (64'sd1 <<< COORD_BITS) - 64'sd1;
  localparam longint          NEG_LIMIT = -(64'sd1 <<< COORD_BITS);

  typedef struct packed {
    out_t x;
    out_t y;
    out_t z;
  } rotated_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  coord_t in_x_in   = '0;
  coord_t in_y_in   = '0;
  coord_t in_z_in   = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  out_t   out_x_out;
  out_t   out_y_out;
  out_t   out_z_out;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  angle_t   ang_x = '0;
  angle_t   ang_y = '0;
  angle_t   ang_z = '0;
  longint   rot_m [9];
  rotated_t rotated_q [$];

  int  mismatches      = 0;
  int  points_sent     = 0;
  int  results_checked = 0;
  int  angle_writes    = 0;
  int  quiet_cycles    = 0;
  int  hold_req        = 0;
  bit  tx_steady       = 1'b0;
  bit  rx_steady       = 1'b0;

  euler_angle_rotation_3d u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x_in   (in_x_in),
    .in_y_in   (in_y_in),
    .in_z_in   (in_z_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x_out (out_x_out),
    .out_y_out (out_y_out),
    .out_z_out (out_z_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // quarter-wave sine, u in [0, 2^30], result Q1.F
  function automatic longint quarter_sin(input longint unsigned u);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned r;
    int k;
    x2 = (u * u) >> 30;
    t  = HALF_PI_TAYLOR[6];
    for (k = 5; k >= 0; k--) begin
      t = HALF_PI_TAYLOR[k] - ((t * x2) >> 30);
    end
    r = (t * u) >> 30;
    r = (r + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS);
    if (r > COEF_UNIT) begin
      r = COEF_UNIT;
    end
    return longint'(r);
  endfunction

  function automatic longint phase_sin(input logic [31:0] ph);
    longint v;
    if (ph[30]) begin
      v = quarter_sin(Q30_UNIT - ph[29:0]);
    end else begin
      v = quarter_sin(ph[29:0]);
    end
    return ph[31] ? -v : v;
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    return (a * b + HALF_LSB) >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint clamp_coef(input longint v);
    if (v > COEF_UNIT) begin
      return COEF_UNIT;
    end
    if (v < -COEF_UNIT) begin
      return -COEF_UNIT;
    end
    return v;
  endfunction

  function automatic void rebuild_matrix();
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    px = 32'(ang_x) << (32 - ANGLE_BITS);
    py = 32'(ang_y) << (32 - ANGLE_BITS);
    pz = 32'(ang_z) << (32 - ANGLE_BITS);
    sx = phase_sin(px);
    cx = phase_sin(px + 32'h4000_0000);
    sy = phase_sin(py);
    cy = phase_sin(py + 32'h4000_0000);
    sz = phase_sin(pz);
    cz = phase_sin(pz + 32'h4000_0000);
    czsy = q_mul(cz, sy);
    szsy = q_mul(sz, sy);
    rot_m[0] = clamp_coef(q_mul(cz, cy));
    rot_m[1] = clamp_coef(-q_mul(sz, cx) + q_mul(czsy, sx));
    rot_m[2] = clamp_coef(q_mul(sz, sx) + q_mul(czsy, cx));
    rot_m[3] = clamp_coef(q_mul(sz, cy));
    rot_m[4] = clamp_coef(q_mul(cz, cx) + q_mul(szsy, sx));
    rot_m[5] = clamp_coef(-q_mul(cz, sx) + q_mul(szsy, cx));
    rot_m[6] = clamp_coef(-sy);
    rot_m[7] = clamp_coef(q_mul(cy, sx));
    rot_m[8] = clamp_coef(q_mul(cy, cx));
  endfunction

  function automatic rotated_t rotate_point(input coord_t x, input coord_t y,
                                            input coord_t z);
    longint   acc;
    longint   v;
    out_t     o [3];
    rotated_t res;
    int       r;
    for (r = 0; r < 3; r++) begin
      acc = rot_m[3*r] * longint'(x) + rot_m[3*r+1] * longint'(y)
          + rot_m[3*r+2] * longint'(z);
      v = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
      if (v > POS_LIMIT) begin
        v = POS_LIMIT;
      end else if (v < NEG_LIMIT) begin
        v = NEG_LIMIT;
      end
      o[r] = out_t'(v);
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return COORD_MIN;
    end
    if (r < 16) begin
      return COORD_MAX;
    end
    if (r < 20) begin
      return '0;
    end
    if (r < 30) begin
      return coord_t'($urandom_range(0, 64)) - coord_t'(32);
    end
    return coord_t'($urandom);
  endfunction

  function automatic angle_t pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return '0;
    end
    if (r < 30) begin
      return ANG_MAX;
    end
    if (r < 45) begin
      return angle_t'($urandom_range(1, 3)) * QUARTER;
    end
    if (r < 55) begin
      return angle_t'($urandom_range(0, 3)) * QUARTER
           + angle_t'($urandom_range(0, 6)) - angle_t'(3);
    end
    return angle_t'($urandom);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_in  <= x;
    in_y_in  <= y;
    in_z_in  <= z;
    do @(posedge clk); while (in_stall !== 1'b0);
    rotated_q.push_back(rotate_point(x, y, z));
    points_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_angle(input logic [CFG_IDX_W-1:0] idx, input angle_t value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ANGLE_X: ang_x = value;
      REG_ANGLE_Y: ang_y = value;
      REG_ANGLE_Z: ang_z = value;
      default: ;
    endcase
    rebuild_matrix();
    angle_writes++;
    // matrix rebuild holds the input off; let it start, then wait it out
    repeat (4) @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic set_angles(input angle_t ax, input angle_t ay, input angle_t az);
    write_angle(REG_ANGLE_X, ax);
    write_angle(REG_ANGLE_Y, ay);
    write_angle(REG_ANGLE_Z, az);
  endtask

  task automatic test_identity();
    send_point(COORD_MAX, COORD_MIN, '0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point('0, '0, '0);
    send_point(-coord_t'(1), coord_t'(1), -coord_t'(1));
    send_point(coord_t'(1), -coord_t'(1), coord_t'(1));
  endtask

  task automatic test_axis_turns();
    angle_t sets [5][3];
    int     i;
    sets = '{
      '{QUARTER, '0, '0},
      '{'0, QUARTER, '0},
      '{'0, '0, QUARTER},
      '{ANG_MAX, ANG_MAX, ANG_MAX},
      '{HALF, HALF + QUARTER, QUARTER / 2}
    };
    for (i = 0; i < 5; i++) begin
      set_angles(sets[i][0], sets[i][1], sets[i][2]);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      send_point(COORD_MIN, COORD_MAX, COORD_MIN);
      send_point(pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  task automatic test_ignored_index();
    int i;
    set_angles(angle_t'($urandom), angle_t'($urandom), angle_t'($urandom));
    write_angle(REG_UNUSED, angle_t'($urandom));
    for (i = 0; i < 8; i++) begin
      send_point(pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  task automatic test_backpressure();
    int i;
    set_angles(pick_angle(), pick_angle(), pick_angle());
    hold_req = 250;
    @(posedge clk);
    tx_steady = 1'b1;
    for (i = 0; i < 40; i++) begin
      send_point(pick_coord(), pick_coord(), pick_coord());
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_random_sweep();
    int p;
    int i;
    for (p = 0; p < PHASES; p++) begin
      set_angles(pick_angle(), pick_angle(), pick_angle());
      tx_steady = (p % 4 == 1);
      rx_steady = (p % 4 == 1) || (p % 4 == 2);
      for (i = 0; i < PHASE_POINTS; i++) begin
        send_point(pick_coord(), pick_coord(), pick_coord());
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // receiver: random stalls, quiet stretches, and one long hold on request
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (rx_steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    rotated_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (rotated_q.size() == 0) begin
        report_mismatch($sformatf("result (%0d %0d %0d) with no item pending",
                                  out_x_out, out_y_out, out_z_out));
      end else begin
        want = rotated_q.pop_front();
        results_checked++;
        if (out_x_out !== want.x) begin
          report_mismatch($sformatf("x_out got %0d want %0d", out_x_out, want.x));
        end
        if (out_y_out !== want.y) begin
          report_mismatch($sformatf("y_out got %0d want %0d", out_y_out, want.y));
        end
        if (out_z_out !== want.z) begin
          report_mismatch($sformatf("z_out got %0d want %0d", out_z_out, want.z));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
        || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
        $display("euler_angle_rotation_3d regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rebuild_matrix();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity();
    test_axis_turns();
    test_ignored_index();
    test_backpressure();
    test_random_sweep();
    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d points, checked %0d rotated results", points_sent, results_checked);
    $display("%0d angle writes incl. zero, full-scale, quarter turns and an unused index",
             angle_writes);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("euler_angle_rotation_3d regression: pass");
    end else begin
      $display("euler_angle_rotation_3d regression: fail");
    end
    $finish;
  end

endmodule
